[hw/rtl/nvqt_pkg.sv]
// nvqt_pkg: shared constants, codes and structs for the nvme queue pair tracker
// used by the interfaces' users, the controller, the datapath and the top level
`timescale 1ns / 1ps

package nvqt_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int ID_W      = 6;
    localparam int DEPTH_W   = 7;
    localparam int GRP_SZ    = 8;
    localparam int GRP_N     = MAX_DEPTH / GRP_SZ;
    localparam int POS_W     = 3;
    localparam int GRP_W     = 3;

    localparam logic [1:0] MODE_SUBMIT   = 2'd0;
    localparam logic [1:0] MODE_COMPLETE = 2'd1;
    localparam logic [1:0] MODE_COLLECT  = 2'd2;

    localparam logic [2:0] REJ_NONE     = 3'd0;
    localparam logic [2:0] REJ_NO_ID    = 3'd1;
    localparam logic [2:0] REJ_FULL     = 3'd2;
    localparam logic [2:0] REJ_STALE    = 3'd3;
    localparam logic [2:0] REJ_NOT_DONE = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] command_dword0;
        logic        entry_phase;
        logic [15:0] entry_command_id;
        logic [5:0]  entry_sq_head;
        logic [14:0] entry_status;
        logic [31:0] entry_result;
        logic [5:0]  collect_id;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  reject_code;
        logic [5:0]  given_id;
        logic [31:0] merged_dword0;
        logic [5:0]  write_slot;
        logic [5:0]  tail_doorbell;
        logic [5:0]  head_doorbell;
        logic [14:0] done_status;
        logic [31:0] done_result;
        logic        success;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic cfg_load;
        logic normalize;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic norm_done;
    } t_sts;

    // one leaf of the free id search
    typedef struct packed {
        logic             hi_hit;
        logic [POS_W-1:0] hi_pos;
        logic             lo_hit;
        logic [POS_W-1:0] lo_pos;
    } t_grp;

    function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] v);
        logic [DEPTH_W-1:0] d;
        d = v;
        if (v < DEPTH_W'(2)) begin
            d = DEPTH_W'(2);
        end else if (v > DEPTH_W'(MAX_DEPTH)) begin
            d = DEPTH_W'(MAX_DEPTH);
        end
        return d;
    endfunction

endpackage

[hw/rtl/nvqt_if.sv]
// nvqt_req_if / nvqt_rsp_if: valid/ready channels for requests and results
// field widths follow nvqt_pkg's t_req and t_rsp
`timescale 1ns / 1ps

interface nvqt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] command_dword0;
    logic        entry_phase;
    logic [15:0] entry_command_id;
    logic [5:0]  entry_sq_head;
    logic [14:0] entry_status;
    logic [31:0] entry_result;
    logic [5:0]  collect_id;

    modport source (
        output valid, mode, command_dword0, entry_phase, entry_command_id,
               entry_sq_head, entry_status, entry_result, collect_id,
        input  ready
    );
    modport sink (
        input  valid, mode, command_dword0, entry_phase, entry_command_id,
               entry_sq_head, entry_status, entry_result, collect_id,
        output ready
    );
endinterface

interface nvqt_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  reject_code;
    logic [5:0]  given_id;
    logic [31:0] merged_dword0;
    logic [5:0]  write_slot;
    logic [5:0]  tail_doorbell;
    logic [5:0]  head_doorbell;
    logic [14:0] done_status;
    logic [31:0] done_result;
    logic        success;

    modport source (
        output valid, accepted, reject_code, given_id, merged_dword0, write_slot,
               tail_doorbell, head_doorbell, done_status, done_result, success,
        input  ready
    );
    modport sink (
        input  valid, accepted, reject_code, given_id, merged_dword0, write_slot,
               tail_doorbell, head_doorbell, done_status, done_result, success,
        output ready
    );
endinterface

[hw/rtl/nvme_io_queue_pair_tracker_unit.sv]
// a request accepted into the capture register has its result registered when it
// commits from the execute state, needed by the registered first level of the free
// id search and the registered status/result store read; commit waits while an
// undrained result is held, and no request is taken before it. a config write keeps
// the request side not ready while start point and tail are reduced to the new depth
// reset (synchronous, active low) clears id flags and pointers, sets phase 1, depth 64
`timescale 1ns / 1ps

module nvme_io_queue_pair_tracker_unit import nvqt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nvqt_req_if.sink           i_req,
    nvqt_rsp_if.source         o_rsp,
    input  logic               i_cfg_wr_en,
    input  logic [DEPTH_W-1:0] i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;
    t_req req;
    t_rsp rsp;

    always_comb begin
        req.mode             = i_req.mode;
        req.command_dword0   = i_req.command_dword0;
        req.entry_phase      = i_req.entry_phase;
        req.entry_command_id = i_req.entry_command_id;
        req.entry_sq_head    = i_req.entry_sq_head;
        req.entry_status     = i_req.entry_status;
        req.entry_result     = i_req.entry_result;
        req.collect_id       = i_req.collect_id;
    end

    nvqt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready)
    );

    nvqt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req         (req),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_rsp         (rsp)
    );

    assign o_rsp.accepted      = rsp.accepted;
    assign o_rsp.reject_code   = rsp.reject_code;
    assign o_rsp.given_id      = rsp.given_id;
    assign o_rsp.merged_dword0 = rsp.merged_dword0;
    assign o_rsp.write_slot    = rsp.write_slot;
    assign o_rsp.tail_doorbell = rsp.tail_doorbell;
    assign o_rsp.head_doorbell = rsp.head_doorbell;
    assign o_rsp.done_status   = rsp.done_status;
    assign o_rsp.done_result   = rsp.done_result;
    assign o_rsp.success       = rsp.success;

endmodule

[hw/rtl/nvqt_ctrl.sv]
// nvqt_ctrl: sequencing of request capture, execute/commit, pointer normalization
// and the result valid flag; depends on nvqt_pkg
`timescale 1ns / 1ps

module nvqt_ctrl import nvqt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  logic i_cfg_wr_en,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_rsp_valid,
    input  logic i_rsp_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_NORM
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   accept;
    logic   commit;

    assign o_req_ready = (r_state == ST_IDLE) && !i_cfg_wr_en;
    assign accept      = i_req_valid && o_req_ready;
    // result register must be empty or draining this cycle
    assign commit      = (r_state == ST_EXEC) && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        o_cmd.capture   = accept;
        o_cmd.commit    = commit;
        o_cmd.cfg_load  = i_cfg_wr_en;
        o_cmd.normalize = (r_state == ST_NORM);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_wr_en) begin
                    n_state = ST_NORM;
                end else if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NORM: begin
                if (!i_cfg_wr_en && i_sts.norm_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_rsp_valid = r_rsp_valid;
        if (commit) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

[hw/rtl/nvqt_dp.sv]
// nvqt_dp: id table flags, status/result store, ring pointers, free id search
// and result register; driven by nvqt_ctrl commands, depends on nvqt_pkg
`timescale 1ns / 1ps

module nvqt_dp import nvqt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  t_req               i_req,
    input  logic [DEPTH_W-1:0] i_cfg_wr_data,
    output t_rsp               o_rsp
);

    logic [DEPTH_W-1:0]   r_depth;
    logic [MAX_DEPTH-1:0] r_busy;
    logic [MAX_DEPTH-1:0] r_fin;
    logic [ID_W-1:0]      r_ss;
    logic [ID_W-1:0]      r_ss_mod;
    logic [ID_W-1:0]      r_tail;
    logic [ID_W-1:0]      r_tail_mod;
    logic [ID_W-1:0]      r_sq_head;
    logic [ID_W-1:0]      r_cq_head;
    logic                 r_phase;

    t_req                 r_req;
    logic [46:0]          r_rd;
    t_grp                 r_grp [GRP_N];
    t_grp                 n_grp [GRP_N];
    t_rsp                 r_rsp, n_rsp;

    // status in the upper bits, result in the lower
    logic [46:0]          mem [MAX_DEPTH];

    logic                 found;
    logic [ID_W-1:0]      cid;
    logic [ID_W-1:0]      ss_next;
    logic [ID_W-1:0]      tail_next;
    logic                 ring_full;
    logic                 phase_ok;
    logic                 id_in_range;
    logic [ID_W-1:0]      cq_next;
    logic                 cq_wrap;
    logic                 coll_done;
    logic                 ss_ge;
    logic                 tail_ge;

    // first level of the search: per group of eight, first free id at or
    // above the start point and first free id anywhere
    always_comb begin
        logic [DEPTH_W-1:0] idx;
        logic               free;
        for (int g = 0; g < GRP_N; g++) begin
            n_grp[g] = '0;
            for (int b = GRP_SZ - 1; b >= 0; b--) begin
                idx  = DEPTH_W'(g * GRP_SZ + b);
                free = !r_busy[idx[ID_W-1:0]] && (idx < r_depth);
                if (free) begin
                    n_grp[g].lo_hit = 1'b1;
                    n_grp[g].lo_pos = POS_W'(b);
                    if (idx >= {1'b0, r_ss_mod}) begin
                        n_grp[g].hi_hit = 1'b1;
                        n_grp[g].hi_pos = POS_W'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < GRP_N; g++) begin
            r_grp[g] <= n_grp[g];
        end
    end

    // second level: pick the first group, wrapping to the lowest free id if none is at or above the start point
    always_comb begin
        logic            hi_found, lo_found;
        logic [ID_W-1:0] hi_cid, lo_cid;
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_cid   = '0;
        lo_cid   = '0;
        for (int g = GRP_N - 1; g >= 0; g--) begin
            if (r_grp[g].hi_hit) begin
                hi_found = 1'b1;
                hi_cid   = {GRP_W'(g), r_grp[g].hi_pos};
            end
            if (r_grp[g].lo_hit) begin
                lo_found = 1'b1;
                lo_cid   = {GRP_W'(g), r_grp[g].lo_pos};
            end
        end
        found = hi_found || lo_found;
        cid   = hi_found ? hi_cid : lo_cid;
    end

    always_comb begin
        logic [DEPTH_W-1:0] cid_p1, tail_p1, cq_p1;
        cid_p1      = {1'b0, cid} + DEPTH_W'(1);
        ss_next     = (cid_p1 == r_depth) ? '0 : cid_p1[ID_W-1:0];
        tail_p1     = {1'b0, r_tail_mod} + DEPTH_W'(1);
        tail_next   = (tail_p1 == r_depth) ? '0 : tail_p1[ID_W-1:0];
        ring_full   = (tail_next == r_sq_head);
        phase_ok    = (r_req.entry_phase == r_phase);
        id_in_range = (r_req.entry_command_id < 16'(r_depth));
        cq_p1       = {1'b0, r_cq_head} + DEPTH_W'(1);
        cq_wrap     = (cq_p1 >= r_depth);
        cq_next     = cq_wrap ? '0 : cq_p1[ID_W-1:0];
        coll_done   = r_fin[r_req.collect_id];
        ss_ge       = ({1'b0, r_ss_mod} >= r_depth);
        tail_ge     = ({1'b0, r_tail_mod} >= r_depth);
    end

    assign o_sts.norm_done = !ss_ge && !tail_ge;

    always_comb begin
        n_rsp = '0;
        unique case (r_req.mode)
            MODE_SUBMIT: begin
                if (!found) begin
                    n_rsp.reject_code = REJ_NO_ID;
                end else if (ring_full) begin
                    n_rsp.reject_code = REJ_FULL;
                end else begin
                    n_rsp.accepted      = 1'b1;
                    n_rsp.given_id      = cid;
                    n_rsp.merged_dword0 = {10'b0, cid, r_req.command_dword0[15:0]};
                    n_rsp.write_slot    = r_tail_mod;
                    n_rsp.tail_doorbell = tail_next;
                end
            end
            MODE_COMPLETE: begin
                if (!phase_ok) begin
                    n_rsp.reject_code = REJ_STALE;
                end else begin
                    n_rsp.accepted      = 1'b1;
                    n_rsp.head_doorbell = cq_next;
                end
            end
            MODE_COLLECT: begin
                if (!coll_done) begin
                    n_rsp.reject_code = REJ_NOT_DONE;
                end else begin
                    n_rsp.accepted    = 1'b1;
                    n_rsp.done_status = r_rd[46:32];
                    n_rsp.done_result = r_rd[31:0];
                    n_rsp.success     = (r_rd[46:32] == 15'd0);
                end
            end
            default: n_rsp = '0;
        endcase
    end

    // request capture, registered table read and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_rd  <= mem[i_req.collect_id];
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_req.mode == MODE_COMPLETE) && phase_ok && id_in_range) begin
            mem[r_req.entry_command_id[ID_W-1:0]] <= {r_req.entry_status, r_req.entry_result};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= DEPTH_W'(MAX_DEPTH);
            r_busy     <= '0;
            r_fin      <= '0;
            r_ss       <= '0;
            r_ss_mod   <= '0;
            r_tail     <= '0;
            r_tail_mod <= '0;
            r_sq_head  <= '0;
            r_cq_head  <= '0;
            r_phase    <= 1'b1;
        end else if (i_cmd.cfg_load) begin
            // reduce the start point and tail against the new depth afterwards
            r_depth    <= clamp_depth(i_cfg_wr_data);
            r_ss_mod   <= r_ss;
            r_tail_mod <= r_tail;
        end else if (i_cmd.normalize) begin
            if (ss_ge) begin
                r_ss_mod <= r_ss_mod - r_depth[ID_W-1:0];
            end
            if (tail_ge) begin
                r_tail_mod <= r_tail_mod - r_depth[ID_W-1:0];
            end
        end else if (i_cmd.commit) begin
            case (r_req.mode)
                MODE_SUBMIT: begin
                    if (found) begin
                        // start point advances even when the ring is full
                        r_busy[cid] <= !ring_full;
                        r_fin[cid]  <= 1'b0;
                        r_ss        <= ss_next;
                        r_ss_mod    <= ss_next;
                        if (!ring_full) begin
                            r_tail     <= tail_next;
                            r_tail_mod <= tail_next;
                        end
                    end
                end
                MODE_COMPLETE: begin
                    if (phase_ok) begin
                        if (id_in_range) begin
                            r_fin[r_req.entry_command_id[ID_W-1:0]] <= 1'b1;
                        end
                        r_sq_head <= r_req.entry_sq_head;
                        r_cq_head <= cq_next;
                        if (cq_wrap) begin
                            r_phase <= !r_phase;
                        end
                    end
                end
                MODE_COLLECT: begin
                    if (coll_done) begin
                        r_busy[r_req.collect_id] <= 1'b0;
                        r_fin[r_req.collect_id]  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp = r_rsp;

endmodule

[bench/tb_nvme_io_queue_pair_tracker_unit.sv]
// tb_nvme_io_queue_pair_tracker_unit: self-checking bench for the nvme queue pair tracker,
// a scoreboard class predicts every result, plain tasks drive requests and depth writes
// depends on nvqt_pkg, nvqt_if (nvqt_req_if, nvqt_rsp_if) and nvme_io_queue_pair_tracker_unit
`timescale 1ns / 1ps

module tb_nvme_io_queue_pair_tracker_unit;
    import nvqt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 140;

    class qpair_scoreboard;
        bit [63:0]   busy;
        bit [63:0]   finished;
        logic [14:0] status_tbl [64];
        logic [31:0] value_tbl [64];
        int          search_ptr;
        int          tail_ptr;
        int          head_ptr;
        int          comp_ptr;
        bit          phase;
        logic [6:0]  depth_reg;
        nvqt_pkg::t_rsp pending_rsp [$];
        int          errors;

        function new();
            busy       = '0;
            finished   = '0;
            for (int i = 0; i < 64; i++) begin
                status_tbl[i] = '0;
                value_tbl[i]  = '0;
            end
            search_ptr = 0;
            tail_ptr   = 0;
            head_ptr   = 0;
            comp_ptr   = 0;
            phase      = 1'b1;
            depth_reg  = 7'd64;
            errors     = 0;
        endfunction

        function void write_depth(logic [6:0] v);
            depth_reg = v;
        endfunction

        function int eff_depth();
            int d;
            d = int'(depth_reg);
            if (d < 2) d = 2;
            if (d > MAX_DEPTH) d = MAX_DEPTH;
            return d;
        endfunction

        // walks the queue pair state for one accepted request
        function nvqt_pkg::t_rsp predict_response(nvqt_pkg::t_req r);
            nvqt_pkg::t_rsp p;
            int d;
            int cid;
            int c;
            int tail;
            int nxt;
            bit found;
            p = '0;
            d = eff_depth();
            found = 1'b0;
            cid = 0;
            case (r.mode)
                MODE_SUBMIT: begin
                    for (int i = 0; i < d; i++) begin
                        c = ((search_ptr % d) + i) % d;
                        if (!found && !busy[c]) begin
                            cid   = c;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        p.reject_code = REJ_NO_ID;
                        return p;
                    end
                    busy[cid]       = 1'b1;
                    finished[cid]   = 1'b0;
                    status_tbl[cid] = '0;
                    value_tbl[cid]  = '0;
                    search_ptr      = (cid + 1) % d;
                    tail = tail_ptr % d;
                    nxt  = (tail + 1) % d;
                    if (nxt == head_ptr) begin
                        // id goes back, search start stays where it moved to
                        busy[cid]     = 1'b0;
                        finished[cid] = 1'b0;
                        p.reject_code = REJ_FULL;
                        return p;
                    end
                    tail_ptr        = nxt;
                    p.accepted      = 1'b1;
                    p.given_id      = cid[5:0];
                    p.merged_dword0 = {10'd0, cid[5:0], r.command_dword0[15:0]};
                    p.write_slot    = tail[5:0];
                    p.tail_doorbell = nxt[5:0];
                end
                MODE_COMPLETE: begin
                    if (r.entry_phase != phase) begin
                        p.reject_code = REJ_STALE;
                        return p;
                    end
                    if (int'(r.entry_command_id) < d) begin
                        status_tbl[r.entry_command_id[5:0]] = r.entry_status;
                        value_tbl[r.entry_command_id[5:0]]  = r.entry_result;
                        finished[r.entry_command_id[5:0]]   = 1'b1;
                    end
                    head_ptr = int'(r.entry_sq_head);
                    comp_ptr++;
                    if (comp_ptr >= d) begin
                        comp_ptr = 0;
                        phase    = !phase;
                    end
                    p.accepted      = 1'b1;
                    p.head_doorbell = comp_ptr[5:0];
                end
                MODE_COLLECT: begin
                    if (!finished[r.collect_id]) begin
                        p.reject_code = REJ_NOT_DONE;
                        return p;
                    end
                    p.accepted    = 1'b1;
                    p.done_status = status_tbl[r.collect_id];
                    p.done_result = value_tbl[r.collect_id];
                    p.success     = (status_tbl[r.collect_id] == '0);
                    busy[r.collect_id]     = 1'b0;
                    finished[r.collect_id] = 1'b0;
                end
                default: begin
                end
            endcase
            return p;
        endfunction

        function void record_request(nvqt_pkg::t_req r);
            pending_rsp.push_back(predict_response(r));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(nvqt_pkg::t_rsp got);
            nvqt_pkg::t_rsp want;
            if (pending_rsp.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("reject_code", 32'(want.reject_code), 32'(got.reject_code));
            compare_field("given_id", 32'(want.given_id), 32'(got.given_id));
            compare_field("merged_dword0", want.merged_dword0, got.merged_dword0);
            compare_field("write_slot", 32'(want.write_slot), 32'(got.write_slot));
            compare_field("tail_doorbell", 32'(want.tail_doorbell), 32'(got.tail_doorbell));
            compare_field("head_doorbell", 32'(want.head_doorbell), 32'(got.head_doorbell));
            compare_field("done_status", 32'(want.done_status), 32'(got.done_status));
            compare_field("done_result", want.done_result, got.done_result);
            compare_field("success", 32'(want.success), 32'(got.success));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [DEPTH_W-1:0] i_cfg_wr_data;
    bit   calm;
    int   idle_cycles;

    nvqt_req_if req_ch ();
    nvqt_rsp_if rsp_ch ();

    qpair_scoreboard sb;

    nvme_io_queue_pair_tracker_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side ready, random bursts until the calm tail of the run
    initial begin
        int  run;
        bit  level;
        run = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run > 0) begin
                run--;
            end else if (calm) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                level = ($urandom_range(0, 2) != 0);
                run   = level ? $urandom_range(1, 40) - 1 : $urandom_range(1, 18) - 1;
                rsp_ch.ready <= level;
            end
        end
    end

    always @(posedge i_clk) begin
        nvqt_pkg::t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.accepted      = rsp_ch.accepted;
            got.reject_code   = rsp_ch.reject_code;
            got.given_id      = rsp_ch.given_id;
            got.merged_dword0 = rsp_ch.merged_dword0;
            got.write_slot    = rsp_ch.write_slot;
            got.tail_doorbell = rsp_ch.tail_doorbell;
            got.head_doorbell = rsp_ch.head_doorbell;
            got.done_status   = rsp_ch.done_status;
            got.done_result   = rsp_ch.done_result;
            got.success       = rsp_ch.success;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic push_request(input t_req r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.mode             <= r.mode;
        req_ch.command_dword0   <= r.command_dword0;
        req_ch.entry_phase      <= r.entry_phase;
        req_ch.entry_command_id <= r.entry_command_id;
        req_ch.entry_sq_head    <= r.entry_sq_head;
        req_ch.entry_status     <= r.entry_status;
        req_ch.entry_result     <= r.entry_result;
        req_ch.collect_id       <= r.collect_id;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.record_request(r);
    endtask

    // depth changes only once every outstanding result has come back
    task automatic write_depth_idle(input logic [DEPTH_W-1:0] v);
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.write_depth(v);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic t_req blank_request(input logic [1:0] mode);
        t_req r;
        r = '0;
        r.mode = mode;
        return r;
    endfunction

    function automatic int pick_id(input bit [63:0] mask);
        int n;
        int k;
        n = $countones(mask);
        if (n == 0) return -1;
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < 64; i++) begin
            if (mask[i]) begin
                if (k == 0) return i;
                k--;
            end
        end
        return -1;
    endfunction

    // mostly well-formed traffic: completions for issued ids, collects of done ids
    function automatic t_req make_random_request();
        t_req r;
        int   d;
        int   roll;
        int   id;
        int   hsel;
        d = sb.eff_depth();
        r.command_dword0   = $urandom;
        r.entry_phase      = 1'($urandom_range(0, 1));
        r.entry_command_id = 16'($urandom);
        r.entry_sq_head    = 6'($urandom);
        r.entry_status     = 15'($urandom);
        r.entry_result     = $urandom;
        r.collect_id       = 6'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 36) begin
            r.mode = MODE_SUBMIT;
            if ($urandom_range(0, 1) == 0) r.command_dword0[31:16] = '0;
        end else if (roll < 70) begin
            r.mode = MODE_COMPLETE;
            if ($urandom_range(0, 9) != 0) r.entry_phase = sb.phase;
            id = pick_id(sb.busy & ~sb.finished);
            if (id >= 0 && $urandom_range(0, 9) != 0) begin
                r.entry_command_id = 16'(id);
            end else if ($urandom_range(0, 1) == 0) begin
                r.entry_command_id = 16'($urandom_range(0, d - 1));
            end
            hsel = $urandom_range(0, 9);
            if (hsel < 7) begin
                r.entry_sq_head = 6'(sb.tail_ptr);
            end else if (hsel < 9) begin
                r.entry_sq_head = 6'($urandom_range(0, d - 1));
            end
            if ($urandom_range(0, 1) == 0) r.entry_status = '0;
        end else if (roll < 98) begin
            r.mode = MODE_COLLECT;
            id = pick_id(sb.finished);
            if (id >= 0 && $urandom_range(0, 4) != 0) r.collect_id = 6'(id);
        end else begin
            r.mode = 2'd3;
        end
        return r;
    endfunction

    initial begin
        t_req r;
        logic [DEPTH_W-1:0] depth_plan [12];
        sb = new();
        calm = 1'b0;
        depth_plan = '{7'd5, 7'd64, 7'd0, 7'd127, 7'd1, 7'd8,
                       7'd100, 7'd16, 7'd3, 7'd65, 7'd2, 7'd33};
        i_rst_n                 <= 1'b0;
        i_cfg_wr_en             <= 1'b0;
        i_cfg_wr_data           <= '0;
        req_ch.valid            <= 1'b0;
        req_ch.mode             <= '0;
        req_ch.command_dword0   <= '0;
        req_ch.entry_phase      <= 1'b0;
        req_ch.entry_command_id <= '0;
        req_ch.entry_sq_head    <= '0;
        req_ch.entry_status     <= '0;
        req_ch.entry_result     <= '0;
        req_ch.collect_id       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset depth: basic submit / complete / collect and their rejects
        r = blank_request(MODE_COLLECT);
        push_request(r);
        r = '1;
        push_request(r);
        r = blank_request(MODE_SUBMIT);
        push_request(r);
        r = blank_request(MODE_SUBMIT);
        r.command_dword0 = 32'hFFFF_FFFF;
        push_request(r);
        r = blank_request(MODE_COMPLETE);
        push_request(r);
        r = blank_request(MODE_COMPLETE);
        r.entry_phase   = 1'b1;
        r.entry_sq_head = 6'd2;
        r.entry_result  = 32'hFFFF_FFFF;
        push_request(r);
        r = blank_request(MODE_COMPLETE);
        r.entry_phase      = 1'b1;
        r.entry_command_id = 16'd1;
        r.entry_sq_head    = 6'd63;
        r.entry_status     = 15'h7FFF;
        push_request(r);
        r = blank_request(MODE_COMPLETE);
        r.entry_phase      = 1'b1;
        r.entry_command_id = 16'hFFFF;
        r.entry_sq_head    = 6'd2;
        r.entry_status     = 15'd5;
        push_request(r);
        r = blank_request(MODE_COLLECT);
        push_request(r);
        r.collect_id = 6'd1;
        push_request(r);
        push_request(r);
        r.collect_id = 6'd63;
        push_request(r);

        // smallest depth: ring full, no free id, ids beyond depth
        write_depth_idle(7'd2);
        r = blank_request(MODE_COMPLETE);
        r.entry_phase      = sb.phase;
        r.entry_command_id = 16'hFFFF;
        push_request(r);
        r = blank_request(MODE_SUBMIT);
        r.command_dword0 = 32'h1234_5678;
        push_request(r);
        push_request(r);
        r = blank_request(MODE_COMPLETE);
        r.entry_phase      = sb.phase;
        r.entry_command_id = 16'd64;
        r.entry_sq_head    = 6'(sb.tail_ptr);
        push_request(r);
        r = blank_request(MODE_SUBMIT);
        push_request(r);
        push_request(r);
        r = blank_request(MODE_COLLECT);
        r.collect_id = 6'd40;
        push_request(r);

        foreach (depth_plan[p]) begin
            write_depth_idle(depth_plan[p]);
            if (p == $size(depth_plan) - 1) calm = 1'b1;
            repeat (PHASE_ITEMS) begin
                r = make_random_request();
                push_request(r);
            end
        end

        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/nvqt_pkg.sv
hw/rtl/nvqt_if.sv
hw/rtl/nvqt_ctrl.sv
hw/rtl/nvqt_dp.sv
hw/rtl/nvme_io_queue_pair_tracker_unit.sv
bench/tb_nvme_io_queue_pair_tracker_unit.sv
